// File: hdl/sbs_pkg.sv
// Shared types and constants of the solenoid burst sequencer.
package sbs_pkg;

	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned PHASE_W    = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DRV_SEL_W  = 3;
	localparam int unsigned DIV_MS     = 1000;

	localparam logic [LEVEL_W-1:0] FULL_DRIVE = 8'd255;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;
	localparam logic [OP_W-1:0] OP_NEXT  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLAME  = 2'd2;

	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_START = 3'd1;
	localparam logic [PHASE_W-1:0] PH_OPEN  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RAMP  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_REST  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_MS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REST_MS    = 3'd4;

	localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL = 8'd80;
	localparam logic [LEN_W-1:0]   RST_OPEN_MS   = 16'd25;
	localparam logic [LEVEL_W-1:0] RST_RAMP_RATE = 8'd50;
	localparam logic [LEN_W-1:0]   RST_BURST_MS  = 16'd500;
	localparam logic [LEN_W-1:0]   RST_REST_MS   = 16'd1000;

	localparam logic [DRV_SEL_W-1:0] DRV_HOLD = 3'd0;
	localparam logic [DRV_SEL_W-1:0] DRV_ZERO = 3'd1;
	localparam logic [DRV_SEL_W-1:0] DRV_FULL = 3'd2;
	localparam logic [DRV_SEL_W-1:0] DRV_MIN  = 3'd3;
	localparam logic [DRV_SEL_W-1:0] DRV_RAMP = 3'd4;

	typedef struct packed {
		logic [DRV_SEL_W-1:0] sel;
		logic [LEVEL_W-1:0]   min_level;
		logic [LEVEL_W-1:0]   limit;
	} level_ctl_t;

endpackage

// File: hdl/sbs_if.sv
// Channel interfaces of the solenoid burst sequencer.
interface sbs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] now_ms;
	logic [7:0]  pwm_limit;

	modport source (output valid, output op, output now_ms, output pwm_limit, input ready);
	modport sink (input valid, input op, input now_ms, input pwm_limit, output ready);
endinterface

interface sbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pwm_level;
	logic       active;
	logic [1:0] flame_mode;
	logic       ignite_pulse;

	modport source (output valid, output pwm_level, output active, output flame_mode,
		output ignite_pulse, input ready);
	modport sink (input valid, input pwm_level, input active, input flame_mode,
		input ignite_pulse, output ready);
endinterface

// File: hdl/sbs_ramp_level.sv
// Ramp level divide, limit cap and drive level register.
module sbs_ramp_level import sbs_pkg::*; #(
	parameter int unsigned RAMP_CLIP_MS = 10000,
	localparam int unsigned ELAPSED_W = $clog2(RAMP_CLIP_MS + 1),
	localparam int unsigned PROD_W = ELAPSED_W + LEVEL_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  level_ctl_t         ctl,
	input  logic [PROD_W-1:0]  prod,
	output logic [LEVEL_W-1:0] level
);

	localparam int unsigned DIV_SH   = $clog2(DIV_MS);
	localparam int unsigned RECIP_SH = PROD_W + DIV_SH;
	localparam int unsigned RECIP_W  = RECIP_SH - DIV_SH + 1;
	localparam int unsigned FULL_W   = PROD_W + RECIP_W;
	localparam int unsigned QUOT_W   = $clog2(RAMP_CLIP_MS * ((2 ** LEVEL_W) - 1) / DIV_MS + 1);
	localparam int unsigned SUM_W    = QUOT_W + 1;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << RECIP_SH) + 64'(DIV_MS) - 64'd1) / 64'(DIV_MS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

	logic [LEVEL_W-1:0] drive_q;
	logic [FULL_W-1:0]  full;
	logic [QUOT_W-1:0]  quot;
	logic [SUM_W-1:0]   sum;
	logic [LEVEL_W-1:0] capped;

	assign full   = FULL_W'(prod) * FULL_W'(RECIP);
	assign quot   = full[RECIP_SH +: QUOT_W];
	assign sum    = SUM_W'(ctl.min_level) + SUM_W'(quot);
	assign capped = (sum > SUM_W'(ctl.limit)) ? ctl.limit : sum[LEVEL_W-1:0];

	always_comb begin
		case (ctl.sel)
			DRV_HOLD: level = drive_q;
			DRV_ZERO: level = '0;
			DRV_FULL: level = FULL_DRIVE;
			DRV_MIN:  level = ctl.min_level;
			DRV_RAMP: level = capped;
			default:  level = drive_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
		end else if (adv) begin
			drive_q <= level;
		end
	end

endmodule

// File: hdl/solenoid_burst_sequencer.sv
// Solenoid burst sequencer top level.
// Takes one command or tick per cycle while the output is not stalled and returns one
// result per item. The first stage holds the item and updates phase, mark time and mode
// as it passes the item on, which sets the rate of one item per clock; the second stage
// holds the elapsed-time product and resolves the drive level by a reciprocal multiply;
// the third is the result register. Input ready drops only when all three stages are
// full and the result is not taken. Configuration writes take effect at once and belong
// only to times when no item is in flight.
module solenoid_burst_sequencer import sbs_pkg::*; #(
	parameter int unsigned RAMP_CLIP_MS = 10000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sbs_in_if.sink                in_ch,
	sbs_out_if.source             out_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned ELAPSED_W = $clog2(RAMP_CLIP_MS + 1);
	localparam int unsigned PROD_W    = ELAPSED_W + LEVEL_W;

	logic [LEVEL_W-1:0] min_level_q;
	logic [LEN_W-1:0]   open_ms_q;
	logic [LEVEL_W-1:0] ramp_rate_q;
	logic [LEN_W-1:0]   burst_ms_q;
	logic [LEN_W-1:0]   rest_ms_q;

	logic [PHASE_W-1:0] phase_q;
	logic [TIME_W-1:0]  mark_q;
	logic [MODE_W-1:0]  mode_q;

	logic               v_s1;
	logic [OP_W-1:0]    op_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [LEVEL_W-1:0] limit_s1;

	logic               v_s2;
	level_ctl_t         ctl_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic               active_s2;
	logic [MODE_W-1:0]  mode_s2;
	logic               ignite_s2;

	logic               out_v_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_active_q;
	logic [MODE_W-1:0]  out_mode_q;
	logic               out_ignite_q;

	logic adv_out, adv_s2, adv_s1, take_s1, take_s2;

	logic [TIME_W-1:0]    elapsed;
	logic [ELAPSED_W-1:0] elapsed_clip;
	logic [PROD_W-1:0]    prod;
	logic [PHASE_W-1:0]   phase_nx;
	logic [TIME_W-1:0]    mark_nx;
	logic [MODE_W-1:0]    mode_nx;
	logic [DRV_SEL_W-1:0] sel_nx;
	logic                 ignite_nx;
	logic [LEVEL_W-1:0]   level_nx;

	assign adv_out = !out_v_q || out_ch.ready;
	assign adv_s2  = !v_s2 || adv_out;
	assign adv_s1  = !v_s1 || adv_s2;
	assign take_s1 = v_s1 && adv_s2;
	assign take_s2 = v_s2 && adv_out;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= RST_MIN_LEVEL;
			open_ms_q   <= RST_OPEN_MS;
			ramp_rate_q <= RST_RAMP_RATE;
			burst_ms_q  <= RST_BURST_MS;
			rest_ms_q   <= RST_REST_MS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MIN_LEVEL: min_level_q <= cfg_data[LEVEL_W-1:0];
				CFG_OPEN_MS:   open_ms_q   <= cfg_data[LEN_W-1:0];
				CFG_RAMP_RATE: ramp_rate_q <= cfg_data[LEVEL_W-1:0];
				CFG_BURST_MS:  burst_ms_q  <= cfg_data[LEN_W-1:0];
				CFG_REST_MS:   rest_ms_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign elapsed      = now_s1 - mark_q;
	assign elapsed_clip = (elapsed > TIME_W'(RAMP_CLIP_MS)) ? ELAPSED_W'(RAMP_CLIP_MS)
		: elapsed[ELAPSED_W-1:0];
	assign prod         = PROD_W'(elapsed_clip) * PROD_W'(ramp_rate_q);

	always_comb begin
		phase_nx  = phase_q;
		mark_nx   = mark_q;
		mode_nx   = mode_q;
		sel_nx    = DRV_HOLD;
		ignite_nx = 1'b0;
		case (op_s1)
			OP_TICK: begin
				case (phase_q)
					PH_IDLE: ;
					PH_START: begin
						sel_nx   = DRV_FULL;
						phase_nx = PH_OPEN;
					end
					PH_OPEN: begin
						if (elapsed > TIME_W'(open_ms_q)) begin
							sel_nx   = DRV_MIN;
							phase_nx = PH_RAMP;
						end
					end
					PH_RAMP: begin
						sel_nx = DRV_RAMP;
						if (mode_q != MODE_FLAME && elapsed > TIME_W'(burst_ms_q)) begin
							sel_nx = DRV_ZERO;
							if (mode_q == MODE_SINGLE) begin
								phase_nx = PH_IDLE;
							end else if (mode_q == MODE_REPEAT) begin
								phase_nx = PH_REST;
								mark_nx  = now_s1;
							end
						end
					end
					PH_REST: begin
						if (elapsed > TIME_W'(rest_ms_q)) begin
							phase_nx  = PH_START;
							mark_nx   = now_s1;
							ignite_nx = 1'b1;
						end
					end
					default: phase_nx = PH_IDLE;
				endcase
			end
			OP_START: begin
				phase_nx = PH_START;
				mark_nx  = now_s1;
			end
			OP_END: begin
				sel_nx   = DRV_ZERO;
				phase_nx = PH_IDLE;
			end
			OP_NEXT: begin
				case (mode_q)
					MODE_SINGLE: mode_nx = MODE_REPEAT;
					MODE_REPEAT: mode_nx = MODE_FLAME;
					default:     mode_nx = MODE_SINGLE;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mark_q  <= '0;
			mode_q  <= MODE_SINGLE;
		end else if (take_s1) begin
			phase_q <= phase_nx;
			mark_q  <= mark_nx;
			mode_q  <= mode_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_ch.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && adv_s1) begin
			op_s1    <= in_ch.op;
			now_s1   <= in_ch.now_ms;
			limit_s1 <= in_ch.pwm_limit;
		end
		if (take_s1) begin
			ctl_s2.sel       <= sel_nx;
			ctl_s2.min_level <= min_level_q;
			ctl_s2.limit     <= limit_s1;
			prod_s2          <= prod;
			active_s2        <= (phase_nx != PH_IDLE);
			mode_s2          <= mode_nx;
			ignite_s2        <= ignite_nx;
		end
		if (take_s2) begin
			out_level_q  <= level_nx;
			out_active_q <= active_s2;
			out_mode_q   <= mode_s2;
			out_ignite_q <= ignite_s2;
		end
	end

	sbs_ramp_level #(
		.RAMP_CLIP_MS(RAMP_CLIP_MS)
	) u_level (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (take_s2),
		.ctl   (ctl_s2),
		.prod  (prod_s2),
		.level (level_nx)
	);

	assign out_ch.valid        = out_v_q;
	assign out_ch.pwm_level    = out_level_q;
	assign out_ch.active       = out_active_q;
	assign out_ch.flame_mode   = out_mode_q;
	assign out_ch.ignite_pulse = out_ignite_q;

endmodule

// File: hdl/sbs_checker.sv
// Port-level checks of the solenoid burst sequencer and their binding.
module sbs_checker import sbs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] pwm_level,
	input logic               active,
	input logic [MODE_W-1:0]  flame_mode,
	input logic               ignite_pulse
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pwm_level) && $stable(active)
			&& $stable(flame_mode) && $stable(ignite_pulse))
		else $error("result changed while stalled");

	a_idle_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> pwm_level == '0)
		else $error("valve driven while idle");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flame_mode == MODE_SINGLE || flame_mode == MODE_REPEAT
			|| flame_mode == MODE_FLAME)
		else $error("unknown flame mode");

	a_ignite_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ignite_pulse |-> active && pwm_level == '0)
		else $error("ignitor pulse outside a closed restart");

endmodule

bind solenoid_burst_sequencer sbs_checker u_sbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.pwm_level   (out_ch.pwm_level),
	.active      (out_ch.active),
	.flame_mode  (out_ch.flame_mode),
	.ignite_pulse(out_ch.ignite_pulse)
);
